// ===== hdl/bmff_pkg.sv =====
`timescale 1ns / 1ps

package bmff_pkg;

  localparam int NUM_COLUMNS_DEF = 256;
  localparam int MAX_ROWS_DEF    = 64;

  localparam int FADE_STEPS      = 90;
  localparam int FADE_POS_RESET  = 50;
  localparam int FADE_CNT_RESET  = 32;
  localparam int NUM_ROWS_RESET  = 16;
  localparam int FALL_STEP_RESET = 171;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_NUM_ROWS  = 1'b0,
    CFG_FALL_STEP = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [14:0] fall_pos;
    logic [5:0]  fade_pos;
    logic [7:0]  fade_cnt;
  } col_state_t;

endpackage

// ===== hdl/bmff_ram.sv =====
`timescale 1ns / 1ps

module bmff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bar_meter_fall_and_fade.sv =====
`timescale 1ns / 1ps
// Threshold write: stored only for a row_index below MAX_ROWS; no result.
// Sample (column below NUM_COLUMNS, else dropped): threshold RAM rows are read in order
// until the first row the level reaches, else the last row (none for a row count of 0);
// then the fall position is updated, then the fade marker, and the column RAM is written
// once the output is free. Result valid the cycle after. One sample at a time.
// Reset: synchronous; control and config registers return to defaults and the column
// RAM is swept one entry per cycle before the first sample or threshold write is taken.
module bar_meter_fall_and_fade #(
  parameter int NUM_COLUMNS = bmff_pkg::NUM_COLUMNS_DEF,
  parameter int MAX_ROWS    = bmff_pkg::MAX_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,

  input  logic                             cfg_write,
  input  logic [bmff_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bmff_pkg::CFG_DATA_W-1:0]  cfg_data,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic [7:0]                       column,
  input  logic [15:0]                      level,
  input  logic [5:0]                       row_index,
  input  logic [15:0]                      row_threshold,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [6:0]                       bar_row,
  output logic [6:0]                       peak_row,
  output logic                             fade_on,
  output logic [5:0]                       fade_row,
  output logic [7:0]                       fade_level
);

  localparam int CW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int TW = $clog2(MAX_ROWS);
  localparam int SW = $bits(bmff_pkg::col_state_t);

  bmff_pkg::state_t state, state_next;

  logic [CW-1:0]  clr_cnt;
  logic [CW-1:0]  col_r;
  logic [15:0]    lvl_r;
  logic [6:0]     rows_r;
  logic [6:0]     r;
  logic [6:0]     y_r;
  logic [14:0]    pos_r;
  logic [5:0]     num_rows;
  logic [11:0]    fall_step;

  logic           accept;
  logic           col_ok;
  logic           ri_ok;
  logic [6:0]     rows_act;
  logic           thr_hit;
  logic           scan_last;
  logic           out_free;
  logic           load;

  logic           thr_we;
  logic [TW-1:0]  thr_waddr;
  logic           thr_re;
  logic [TW-1:0]  thr_raddr;
  logic [15:0]    thr_rdata;

  logic           col_we;
  logic [CW-1:0]  col_waddr;
  logic [SW-1:0]  col_wdata;
  logic           col_re;
  logic [CW-1:0]  col_raddr;
  logic [SW-1:0]  col_rdata;

  bmff_pkg::col_state_t cs;
  bmff_pkg::col_state_t new_word;
  bmff_pkg::col_state_t reset_word;

  logic           grow;
  logic [14:0]    y_pos;
  logic [14:0]    pos_add;
  logic [14:0]    pos_calc;
  logic [6:0]     y_calc;
  logic           hit_f;
  logic [5:0]     fp1;
  logic [7:0]     fc1;
  logic           on_f;
  logic [7:0]     fc2;
  logic [5:0]     fp2;

  bmff_ram #(
    .WIDTH (16),
    .DEPTH (MAX_ROWS),
    .AW    (TW)
  ) u_thr_ram (
    .clk   (clk),
    .we    (thr_we),
    .waddr (thr_waddr),
    .wdata (row_threshold),
    .re    (thr_re),
    .raddr (thr_raddr),
    .rdata (thr_rdata)
  );

  bmff_ram #(
    .WIDTH (SW),
    .DEPTH (NUM_COLUMNS),
    .AW    (CW)
  ) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .re    (col_re),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  assign in_stall  = state != bmff_pkg::ST_IDLE;
  assign accept    = in_valid && !in_stall;
  assign col_ok    = 32'(column) < NUM_COLUMNS;
  assign ri_ok     = 32'(row_index) < MAX_ROWS;
  assign rows_act  = (7'(num_rows) > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : 7'(num_rows);
  assign thr_hit   = lvl_r >= thr_rdata;
  assign scan_last = (r + 7'd1) == rows_r;
  assign out_free  = !out_valid || !out_stall;

  // fall position update
  assign cs       = bmff_pkg::col_state_t'(col_rdata);
  assign y_pos    = {y_r, 8'h00};
  assign grow     = y_pos > cs.fall_pos;
  assign pos_add  = cs.fall_pos + 15'(fall_step);
  assign pos_calc = grow ? pos_add : y_pos;
  assign y_calc   = grow ? pos_add[14:8] : y_r;

  // fade marker update
  assign hit_f = y_r <= {1'b0, cs.fade_pos};
  assign fp1   = hit_f ? y_r[5:0] : cs.fade_pos;
  assign fc1   = hit_f ? 8'(bmff_pkg::FADE_STEPS) : cs.fade_cnt;
  assign on_f  = fc1 != 8'd0;
  assign fc2   = on_f ? fc1 - 8'd1 : 8'd0;
  assign fp2   = (fc2 == 8'd0) ? rows_r[5:0] : fp1;

  assign new_word.fall_pos   = pos_r;
  assign new_word.fade_pos   = fp2;
  assign new_word.fade_cnt   = fc2;
  assign reset_word.fall_pos = '0;
  assign reset_word.fade_pos = 6'(bmff_pkg::FADE_POS_RESET);
  assign reset_word.fade_cnt = 8'(bmff_pkg::FADE_CNT_RESET);

  always_comb begin
    state_next = state;
    unique case (state)
      bmff_pkg::ST_CLEAR: begin
        if (clr_cnt == CW'(NUM_COLUMNS - 1)) begin
          state_next = bmff_pkg::ST_IDLE;
        end
      end
      bmff_pkg::ST_IDLE: begin
        if (accept && func && col_ok) begin
          state_next = (rows_act == 7'd0) ? bmff_pkg::ST_CALC : bmff_pkg::ST_SCAN;
        end
      end
      bmff_pkg::ST_SCAN: begin
        if (thr_hit || scan_last) begin
          state_next = bmff_pkg::ST_CALC;
        end
      end
      bmff_pkg::ST_CALC: begin
        state_next = bmff_pkg::ST_WRITE;
      end
      bmff_pkg::ST_WRITE: begin
        if (out_free) begin
          state_next = bmff_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bmff_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    thr_we    = 1'b0;
    thr_waddr = TW'(row_index);
    thr_re    = 1'b0;
    thr_raddr = TW'(r + 7'd1);
    col_re    = 1'b0;
    col_raddr = CW'(column);
    col_we    = 1'b0;
    col_waddr = col_r;
    col_wdata = new_word;
    load      = 1'b0;
    unique case (state)
      bmff_pkg::ST_CLEAR: begin
        col_we    = 1'b1;
        col_waddr = clr_cnt;
        col_wdata = reset_word;
      end
      bmff_pkg::ST_IDLE: begin
        thr_we    = accept && !func && ri_ok;
        thr_re    = accept && func;
        thr_raddr = '0;
        col_re    = accept && func;
      end
      bmff_pkg::ST_SCAN: begin
        thr_re = 1'b1;
      end
      bmff_pkg::ST_CALC: begin
      end
      bmff_pkg::ST_WRITE: begin
        col_we = out_free;
        load   = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bmff_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      num_rows  <= 6'(bmff_pkg::NUM_ROWS_RESET);
      fall_step <= 12'(bmff_pkg::FALL_STEP_RESET);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          bmff_pkg::CFG_NUM_ROWS:  num_rows  <= cfg_data[5:0];
          bmff_pkg::CFG_FALL_STEP: fall_step <= cfg_data[11:0];
        endcase
      end
      if (state == bmff_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + CW'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      bmff_pkg::ST_IDLE: begin
        if (accept) begin
          col_r  <= CW'(column);
          lvl_r  <= level;
          rows_r <= rows_act;
          r      <= '0;
          y_r    <= '0;
        end
      end
      bmff_pkg::ST_SCAN: begin
        if (thr_hit) begin
          y_r <= r;
        end else if (scan_last) begin
          y_r <= rows_r;
        end else begin
          r <= r + 7'd1;
        end
      end
      bmff_pkg::ST_CALC: begin
        pos_r <= pos_calc;
        y_r   <= y_calc;
      end
      bmff_pkg::ST_WRITE: begin
        if (load) begin
          bar_row    <= y_r;
          peak_row   <= pos_r[14:8];
          fade_on    <= on_f;
          fade_row   <= on_f ? fp1 : 6'd0;
          fade_level <= on_f ? fc2 : 8'd0;
        end
      end
      default: begin
      end
    endcase
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == bmff_pkg::ST_SCAN |-> r < rows_r)
    else $error("scan index past row count");

  a_bar_peak_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bar_row == peak_row)
    else $error("bar row and peak row differ");

  a_fade_off_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fade_on |-> fade_row == 6'd0 && fade_level == 8'd0)
    else $error("fade fields set with marker off");

  a_result_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == bmff_pkg::ST_WRITE)
    else $error("result raised outside write-back");

endmodule
